FILE: design/dfhe_pkg.sv
// Package: shared types, code tables and constants of the fixed-Huffman encoder.
`timescale 1ns / 1ps
`default_nettype none

package dfhe_pkg;

   // Item kinds
   typedef enum logic [1:0] {
      FUNC_LITERAL = 2'd0,
      FUNC_PAIR    = 2'd1,
      FUNC_START   = 2'd2,
      FUNC_END     = 2'd3
   } func_type;

   localparam int LEN_SYMS  = 29;
   localparam int DIST_SYMS = 30;

   // Length and distance range bounds
   localparam logic [8:0]  LEN_MIN  = 9'd3;
   localparam logic [8:0]  LEN_MAX  = 9'd258;
   localparam logic [15:0] DIST_MIN = 16'd1;
   localparam logic [15:0] DIST_MAX = 16'd32768;

   // Literals below this value use the 8-bit code
   localparam logic [7:0] LIT_SPLIT    = 8'd144;
   localparam logic [7:0] LIT_OFFSET   = 8'd48;
   // Length symbols up to this index use the 7-bit code (symbol 279)
   localparam logic [4:0] LSYM_SPLIT   = 5'd22;
   // 8-bit length code is index - 23 + 192
   localparam logic [7:0] LSYM_OFFSET8 = 8'd169;

   // Stream start: zlib header 0x78 0x5E, BFINAL=1, BTYPE=01
   localparam logic [30:0] START_BITS = 31'h0003_5E78;
   localparam logic [4:0]  START_LEN  = 5'd19;
   // End of block: symbol 256, seven zero bits
   localparam logic [4:0]  EOB_LEN    = 5'd7;

   localparam logic [8:0] LEN_BASE [LEN_SYMS] = '{
      9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,
      9'd11,  9'd13,  9'd15,  9'd17,  9'd19,  9'd23,  9'd27,  9'd31,
      9'd35,  9'd43,  9'd51,  9'd59,  9'd67,  9'd83,  9'd99,  9'd115,
      9'd131, 9'd163, 9'd195, 9'd227, 9'd258
   };
   localparam logic [2:0] LEN_EXTRA [LEN_SYMS] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd0
   };
   localparam logic [15:0] DIST_BASE [DIST_SYMS] = '{
      16'd1,     16'd2,     16'd3,     16'd4,     16'd5,     16'd7,
      16'd9,     16'd13,    16'd17,    16'd25,    16'd33,    16'd49,
      16'd65,    16'd97,    16'd129,   16'd193,   16'd257,   16'd385,
      16'd513,   16'd769,   16'd1025,  16'd1537,  16'd2049,  16'd3073,
      16'd4097,  16'd6145,  16'd8193,  16'd12289, 16'd16385, 16'd24577
   };
   localparam logic [3:0] DIST_EXTRA [DIST_SYMS] = '{
      4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd2,  4'd2,
      4'd3,  4'd3,  4'd4,  4'd4,  4'd5,  4'd5,  4'd6,  4'd6,
      4'd7,  4'd7,  4'd8,  4'd8,  4'd9,  4'd9,  4'd10, 4'd10,
      4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
   };

   // Stage 1 -> 2: clamped fields and symbol indexes
   typedef struct packed {
      func_type    func;
      logic [7:0]  literal_byte;
      logic [8:0]  len;
      logic [15:0] distance;
      logic [4:0]  lsym;
      logic [4:0]  dsym;
   } sym_type;

   // Stage 2 -> 3: code pieces, each with its bit count but the fixed 5-bit distance code
   typedef struct packed {
      func_type    func;
      logic [8:0]  code;
      logic [3:0]  code_n;
      logic [4:0]  lext;
      logic [2:0]  lext_n;
      logic [4:0]  dcode;
      logic [12:0] dext;
      logic [3:0]  dext_n;
   } piece_type;

endpackage

`default_nettype wire

FILE: design/dfhe_ifs.sv
// Interfaces: request and response channels of the fixed-Huffman encoder.
`timescale 1ns / 1ps
`default_nettype none

interface dfhe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  literal_byte;
   logic [8:0]  match_length;
   logic [15:0] match_distance;

   modport source (output valid, output func, output literal_byte,
                   output match_length, output match_distance, input ready);
   modport sink   (input valid, input func, input literal_byte,
                   input match_length, input match_distance, output ready);
endinterface

interface dfhe_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] chunk_bits;
   logic [4:0]  chunk_length;

   modport source (output valid, output chunk_bits, output chunk_length, input ready);
   modport sink   (input valid, input chunk_bits, input chunk_length, output ready);
endinterface

`default_nettype wire

FILE: design/deflate_fixed_huffman_encoder.sv
// Top level: three-stage DEFLATE fixed-Huffman symbol encoder.
// The encoder takes one symbol transaction per cycle unless the output stalls and
// returns one bit chunk (first bit in bit 0) from the stage 3 register. Stage 1
// clamps the match fields and finds the length and distance symbols, stage 2 forms
// the Huffman codes and extra-bit values, stage 3 packs them into the chunk and is
// the output register. Each stage advances when it is empty or the stage after it
// moves, so a stall on the response side backs up one stage at a time and req_if
// drops ready only once all three stages hold data.
`timescale 1ns / 1ps
`default_nettype none

module deflate_fixed_huffman_encoder (
   input  wire logic  clock,
   input  wire logic  reset,
   dfhe_req_if.sink   req_if,
   dfhe_rsp_if.source rsp_if
);

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_en, s2_en, s3_en;

   assign s3_en = !s3_valid_ff || rsp_if.ready;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_if.ready = s1_en;

   assign s1_valid_in = s1_en ? req_if.valid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = s3_en ? s2_valid_ff  : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1: clamp and symbol search
   dfhe_pkg::sym_type s1_ff, s1_in;
   logic [8:0]  len_c;
   logic [15:0] dist_c;

   always_comb begin
      len_c = req_if.match_length;
      if (len_c < dfhe_pkg::LEN_MIN) len_c = dfhe_pkg::LEN_MIN;
      if (len_c > dfhe_pkg::LEN_MAX) len_c = dfhe_pkg::LEN_MAX;
      dist_c = req_if.match_distance;
      if (dist_c < dfhe_pkg::DIST_MIN) dist_c = dfhe_pkg::DIST_MIN;
      if (dist_c > dfhe_pkg::DIST_MAX) dist_c = dfhe_pkg::DIST_MAX;

      s1_in.func         = dfhe_pkg::func_type'(req_if.func);
      s1_in.literal_byte = req_if.literal_byte;
      s1_in.len          = len_c;
      s1_in.distance     = dist_c;
      s1_in.lsym         = '0;
      s1_in.dsym         = '0;
      // Highest table entry whose base does not exceed the value
      for (int i = 1; i < dfhe_pkg::LEN_SYMS; i++) begin
         if (dfhe_pkg::LEN_BASE[i] <= len_c) s1_in.lsym = 5'(i);
      end
      for (int j = 1; j < dfhe_pkg::DIST_SYMS; j++) begin
         if (dfhe_pkg::DIST_BASE[j] <= dist_c) s1_in.dsym = 5'(j);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_ff <= s1_in;
   end

   // Stage 2: Huffman codes and extra-bit values
   dfhe_pkg::piece_type s2_ff, s2_in;
   logic [7:0]  lit8;
   logic [7:0]  lit8_r;
   logic [8:0]  lit9;
   logic [6:0]  lcode7;
   logic [6:0]  lcode7_r;
   logic [7:0]  lcode8;
   logic [7:0]  lcode8_r;
   logic [8:0]  ldiff;
   logic [15:0] ddiff;

   always_comb begin
      lit8     = s1_ff.literal_byte + dfhe_pkg::LIT_OFFSET;
      lit9     = {1'b1, s1_ff.literal_byte};
      lcode7   = 7'({2'b00, s1_ff.lsym} + 7'd1);
      lcode8   = {3'b000, s1_ff.lsym} + dfhe_pkg::LSYM_OFFSET8;
      lit8_r   = {<<{lit8}};
      lcode7_r = {<<{lcode7}};
      lcode8_r = {<<{lcode8}};
      ldiff    = s1_ff.len  - dfhe_pkg::LEN_BASE[s1_ff.lsym];
      ddiff    = s1_ff.distance - dfhe_pkg::DIST_BASE[s1_ff.dsym];

      s2_in.func   = s1_ff.func;
      s2_in.code   = '0;
      s2_in.code_n = '0;
      s2_in.lext   = ldiff[4:0];
      s2_in.lext_n = dfhe_pkg::LEN_EXTRA[s1_ff.lsym];
      s2_in.dcode  = {<<{s1_ff.dsym}};
      s2_in.dext   = ddiff[12:0];
      s2_in.dext_n = dfhe_pkg::DIST_EXTRA[s1_ff.dsym];
      case (s1_ff.func)
         dfhe_pkg::FUNC_LITERAL: begin
            if (s1_ff.literal_byte < dfhe_pkg::LIT_SPLIT) begin
               s2_in.code   = {1'b0, lit8_r};
               s2_in.code_n = 4'd8;
            end else begin
               s2_in.code   = {<<{lit9}};
               s2_in.code_n = 4'd9;
            end
         end
         dfhe_pkg::FUNC_PAIR: begin
            if (s1_ff.lsym <= dfhe_pkg::LSYM_SPLIT) begin
               s2_in.code   = {2'b00, lcode7_r};
               s2_in.code_n = 4'd7;
            end else begin
               s2_in.code   = {1'b0, lcode8_r};
               s2_in.code_n = 4'd8;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_en) s2_ff <= s2_in;
   end

   // Stage 3: pack pieces into the output chunk
   logic [30:0] bits_ff, bits_in;
   logic [4:0]  blen_ff, blen_in;
   logic [4:0]  pos_l, pos_d, pos_x;
   logic [5:0]  pos_end;

   always_comb begin
      pos_l   = {1'b0, s2_ff.code_n};
      pos_d   = pos_l + {2'b00, s2_ff.lext_n};
      pos_x   = pos_d + 5'd5;
      pos_end = {1'b0, pos_x} + {2'b00, s2_ff.dext_n};
      bits_in = '0;
      blen_in = '0;
      case (s2_ff.func)
         dfhe_pkg::FUNC_LITERAL: begin
            bits_in = {22'd0, s2_ff.code};
            blen_in = {1'b0, s2_ff.code_n};
         end
         dfhe_pkg::FUNC_PAIR: begin
            bits_in = {22'd0, s2_ff.code}
                    | ({26'd0, s2_ff.lext}  << pos_l)
                    | ({26'd0, s2_ff.dcode} << pos_d)
                    | ({18'd0, s2_ff.dext}  << pos_x);
            blen_in = pos_end[4:0];
         end
         dfhe_pkg::FUNC_START: begin
            bits_in = dfhe_pkg::START_BITS;
            blen_in = dfhe_pkg::START_LEN;
         end
         default: begin
            bits_in = '0;
            blen_in = dfhe_pkg::EOB_LEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         bits_ff <= bits_in;
         blen_ff <= blen_in;
      end
   end

   assign rsp_if.valid        = s3_valid_ff;
   assign rsp_if.chunk_bits   = bits_ff;
   assign rsp_if.chunk_length = blen_ff;

endmodule

`default_nettype wire

FILE: design/dfhe_checker.sv
// Checker: port-level assertions for the fixed-Huffman encoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module dfhe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [30:0] chunk_bits,
   input wire logic [4:0]  chunk_length
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the output stage empty, nothing can hold back a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   // Bits above the chunk length are zero
   a_clean_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((chunk_bits >> chunk_length) == 31'd0))
      else $error("stray bits above chunk length");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(chunk_bits)
                                 && $stable(chunk_length))
      else $error("stalled response changed");

endmodule

bind deflate_fixed_huffman_encoder dfhe_checker u_dfhe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .chunk_bits   (rsp_if.chunk_bits),
   .chunk_length (rsp_if.chunk_length)
);

`default_nettype wire
